// ===== rtl/hpg_pkg.sv =====
// ----------------------------------------------------------------------------
// hpg_pkg: shared constants and types for the Halton point generator
// Field widths, counter sizing, register indexes and lane control struct.
// ----------------------------------------------------------------------------
package hpg_pkg;

   localparam int HPG_INDEX_BITS = 20;
   localparam int HPG_FRAC_BITS  = 24;
   localparam int HPG_BASE_BITS  = 8;
   localparam int HPG_ACC_BITS   = HPG_INDEX_BITS + HPG_BASE_BITS;
   localparam int HPG_STEP_MAX   = (HPG_INDEX_BITS > HPG_FRAC_BITS) ?
                                   HPG_INDEX_BITS : HPG_FRAC_BITS;
   localparam int HPG_CNT_BITS   = $clog2(HPG_STEP_MAX);
   localparam int HPG_CSR_IDX_BITS = 2;

   localparam logic [HPG_BASE_BITS-1:0] HPG_BASE_MIN     = HPG_BASE_BITS'(2);
   localparam logic [HPG_BASE_BITS-1:0] HPG_BASE_X_RESET = HPG_BASE_BITS'(2);
   localparam logic [HPG_BASE_BITS-1:0] HPG_BASE_Y_RESET = HPG_BASE_BITS'(3);
   localparam logic [HPG_BASE_BITS-1:0] HPG_BASE_Z_RESET = HPG_BASE_BITS'(5);

   typedef enum logic [HPG_CSR_IDX_BITS-1:0] {
      CSR_BASE_X = 2'd0,
      CSR_BASE_Y = 2'd1,
      CSR_BASE_Z = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic start;
      logic clear;
   } hpg_lane_ctl_type;

endpackage

// ===== rtl/hpg_lane.sv =====
// ----------------------------------------------------------------------------
// hpg_lane: radical inverse of one coordinate
// Bit-serial digit extraction by the base, digit reversal, then bit-serial
// long division of the reversed digits by base^digits into a fraction.
// ----------------------------------------------------------------------------
module hpg_lane import hpg_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  hpg_lane_ctl_type          ctl,
   input  logic [HPG_BASE_BITS-1:0]  base,
   input  logic [HPG_INDEX_BITS-1:0] point_index,
   output logic                      done,
   output logic [HPG_FRAC_BITS-1:0]  frac
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIGIT,
      ST_ACCUM,
      ST_FRAC,
      ST_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic [HPG_CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [HPG_BASE_BITS-1:0]  base_ff, base_in;
   logic [HPG_INDEX_BITS-1:0] quo_ff, quo_in;
   logic [HPG_BASE_BITS-1:0]  rem_ff, rem_in;
   logic [HPG_ACC_BITS-1:0]   rev_ff, rev_in;
   logic [HPG_ACC_BITS-1:0]   den_ff, den_in;
   logic [HPG_FRAC_BITS-1:0]  frac_ff, frac_in;

   logic [HPG_BASE_BITS:0]               div_trial, div_diff;
   logic                                 div_ge;
   logic [HPG_ACC_BITS:0]                frac_trial, frac_diff;
   logic                                 frac_ge;
   logic [HPG_ACC_BITS+HPG_BASE_BITS-1:0] rev_prod, den_prod;

   assign div_trial  = {rem_ff, quo_ff[HPG_INDEX_BITS-1]};
   assign div_ge     = div_trial >= {1'b0, base_ff};
   assign div_diff   = div_trial - {1'b0, base_ff};
   assign frac_trial = {rev_ff, 1'b0};
   assign frac_ge    = frac_trial >= {1'b0, den_ff};
   assign frac_diff  = frac_trial - {1'b0, den_ff};
   assign rev_prod   = rev_ff * base_ff;
   assign den_prod   = den_ff * base_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      base_in  = base_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      rev_in   = rev_ff;
      den_in   = den_ff;
      frac_in  = frac_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               base_in  = (base < HPG_BASE_MIN) ? HPG_BASE_MIN : base;
               quo_in   = point_index;
               rem_in   = '0;
               rev_in   = '0;
               den_in   = HPG_ACC_BITS'(1);
               cnt_in   = '0;
               state_in = (point_index == '0) ? ST_FRAC : ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            rem_in = div_ge ? div_diff[HPG_BASE_BITS-1:0] : div_trial[HPG_BASE_BITS-1:0];
            quo_in = {quo_ff[HPG_INDEX_BITS-2:0], div_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == HPG_CNT_BITS'(HPG_INDEX_BITS - 1)) begin
               cnt_in   = '0;
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            // append the digit below the reversed value
            rev_in   = rev_prod[HPG_ACC_BITS-1:0] + HPG_ACC_BITS'(rem_ff);
            den_in   = den_prod[HPG_ACC_BITS-1:0];
            rem_in   = '0;
            state_in = (quo_ff == '0) ? ST_FRAC : ST_DIGIT;
         end
         ST_FRAC: begin
            rev_in  = frac_ge ? frac_diff[HPG_ACC_BITS-1:0] : frac_trial[HPG_ACC_BITS-1:0];
            frac_in = {frac_ff[HPG_FRAC_BITS-2:0], frac_ge};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == HPG_CNT_BITS'(HPG_FRAC_BITS - 1)) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (ctl.clear) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      base_ff <= base_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      rev_ff  <= rev_in;
      den_ff  <= den_in;
      frac_ff <= frac_in;
   end

   assign done = (state_ff == ST_DONE);
   assign frac = frac_ff;

   a_frac_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FRAC) |-> (rev_ff < den_ff))
      else $error("remainder not below denominator");

   a_digit_below_base: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACCUM) |-> ((rem_ff < base_ff) && (base_ff >= HPG_BASE_MIN)))
      else $error("digit out of range for base");

   a_done_after_frac: assert property (@(posedge clock) disable iff (reset)
      $rose(done) |-> ($past(state_ff) == ST_FRAC))
      else $error("lane finished without division pass");

endmodule

// ===== rtl/halton_point_generator.sv =====
// ----------------------------------------------------------------------------
// halton_point_generator: three-axis Halton point coordinates
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | req_point_index
//   rsp     | out       | rsp_valid/stall    | rsp_frac_x, rsp_frac_y, rsp_frac_z
//   csr     | in        | csr_valid/ready    | csr_index, csr_data
//
// The slowest axis sets the time per point: each base digit costs one
// bit-serial divide pass over the index, and the fraction one restoring
// division step per output bit.
// Reset restores bases 2, 3, 5 and empties the lanes and output register.
// A new point is taken while a finished result waits in the output register.
// ----------------------------------------------------------------------------
module halton_point_generator import hpg_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [HPG_INDEX_BITS-1:0]   req_point_index,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [HPG_FRAC_BITS-1:0]    rsp_frac_x,
   output logic [HPG_FRAC_BITS-1:0]    rsp_frac_y,
   output logic [HPG_FRAC_BITS-1:0]    rsp_frac_z,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [HPG_CSR_IDX_BITS-1:0] csr_index,
   input  logic [HPG_BASE_BITS-1:0]    csr_data
);

   logic [HPG_BASE_BITS-1:0] base_x_ff, base_y_ff, base_z_ff;
   logic                     busy_ff, rsp_valid_ff;
   logic [HPG_FRAC_BITS-1:0] frac_x_ff, frac_y_ff, frac_z_ff;

   hpg_lane_ctl_type         lane_ctl;
   logic [2:0]               lane_done;
   logic [HPG_FRAC_BITS-1:0] lane_frac_x, lane_frac_y, lane_frac_z;
   logic                     req_xfer, rsp_xfer, load_rsp;

   assign csr_ready = 1'b1;
   assign req_stall = busy_ff;
   assign req_xfer  = req_valid && !busy_ff;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign load_rsp  = busy_ff && (&lane_done) && (!rsp_valid_ff || !rsp_stall);

   assign lane_ctl.start = req_xfer;
   assign lane_ctl.clear = load_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_x_ff <= HPG_BASE_X_RESET;
         base_y_ff <= HPG_BASE_Y_RESET;
         base_z_ff <= HPG_BASE_Z_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BASE_X: base_x_ff <= csr_data;
            CSR_BASE_Y: base_y_ff <= csr_data;
            CSR_BASE_Z: base_z_ff <= csr_data;
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            busy_ff <= 1'b1;
         end else if (load_rsp) begin
            busy_ff <= 1'b0;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_xfer) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (load_rsp) begin
         frac_x_ff <= lane_frac_x;
         frac_y_ff <= lane_frac_y;
         frac_z_ff <= lane_frac_z;
      end
   end

   hpg_lane u_lane_x (
      .clock       (clock),
      .reset       (reset),
      .ctl         (lane_ctl),
      .base        (base_x_ff),
      .point_index (req_point_index),
      .done        (lane_done[0]),
      .frac        (lane_frac_x)
   );

   hpg_lane u_lane_y (
      .clock       (clock),
      .reset       (reset),
      .ctl         (lane_ctl),
      .base        (base_y_ff),
      .point_index (req_point_index),
      .done        (lane_done[1]),
      .frac        (lane_frac_y)
   );

   hpg_lane u_lane_z (
      .clock       (clock),
      .reset       (reset),
      .ctl         (lane_ctl),
      .base        (base_z_ff),
      .point_index (req_point_index),
      .done        (lane_done[2]),
      .frac        (lane_frac_z)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_frac_x = frac_x_ff;
   assign rsp_frac_y = frac_y_ff;
   assign rsp_frac_z = frac_z_ff;

   a_lanes_not_done_after_start: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (lane_done == 3'b000))
      else $error("lane done right after transfer in");

   a_done_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      (lane_done != 3'b000) |-> busy_ff)
      else $error("lane done with no point in flight");

   a_idle_implies_result: assert property (@(posedge clock) disable iff (reset)
      (!reset && $past(!reset) && $fell(busy_ff)) |-> rsp_valid_ff)
      else $error("point retired without a result");

endmodule

// ===== verif/halton_point_generator_tb.sv =====
// ----------------------------------------------------------------------------
// halton_point_generator_tb: self-checking bench for the Halton point generator
// Drives point indexes through the req channel, programs the three radix
// registers between phases, and checks every rsp transfer against a local
// radical-inverse predictor or a directed row's expected values. The table runs
// first, then random phases with and without sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module halton_point_generator_tb;
   import hpg_pkg::*;

   localparam logic [HPG_CSR_IDX_BITS-1:0] CSR_SPARE = 2'd3;
   localparam int RUN_LIMIT       = 4000000;
   localparam int DRAIN_CYCLES    = 500;
   localparam int HOLD_CYCLES     = 3000;
   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 137;

   typedef struct packed {
      logic [HPG_FRAC_BITS-1:0] x;
      logic [HPG_FRAC_BITS-1:0] y;
      logic [HPG_FRAC_BITS-1:0] z;
   } point_coords_type;

   typedef enum logic {ROW_POINT, ROW_BASES} row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic [HPG_INDEX_BITS-1:0] index;
      logic                      typed;
      point_coords_type          want;
      logic [HPG_BASE_BITS-1:0]  bx;
      logic [HPG_BASE_BITS-1:0]  by;
      logic [HPG_BASE_BITS-1:0]  bz;
   } stim_row_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [HPG_INDEX_BITS-1:0]   req_point_index = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [HPG_FRAC_BITS-1:0]    rsp_frac_x;
   logic [HPG_FRAC_BITS-1:0]    rsp_frac_y;
   logic [HPG_FRAC_BITS-1:0]    rsp_frac_z;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [HPG_CSR_IDX_BITS-1:0] csr_index = '0;
   logic [HPG_BASE_BITS-1:0]    csr_data = '0;

   logic [HPG_BASE_BITS-1:0] radix_x = HPG_BASE_X_RESET;
   logic [HPG_BASE_BITS-1:0] radix_y = HPG_BASE_Y_RESET;
   logic [HPG_BASE_BITS-1:0] radix_z = HPG_BASE_Z_RESET;

   point_coords_type coords_due [$];
   point_coords_type head_coords;
   stim_row_type     steps [$];
   int               fault_count = 0;
   int               cycle_count = 0;
   int               gap_pct = 0;
   int               stall_pct = 0;
   int               hold_left = 0;
   logic             hold_trigger = 1'b0;

   halton_point_generator uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_point_index (req_point_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_frac_x      (rsp_frac_x),
      .rsp_frac_y      (rsp_frac_y),
      .rsp_frac_z      (rsp_frac_z),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // mirror the base-b digits behind the radix point, truncate to FRAC_BITS
   function automatic logic [HPG_FRAC_BITS-1:0] mirror_fraction(
      input logic [HPG_BASE_BITS-1:0]  radix,
      input logic [HPG_INDEX_BITS-1:0] index);
      logic [63:0] b;
      logic [63:0] n;
      logic [63:0] mirrored;
      logic [63:0] scale;
      logic [63:0] quot;
      b = (radix < HPG_BASE_MIN) ? 64'(HPG_BASE_MIN) : 64'(radix);
      n = 64'(index);
      mirrored = 64'd0;
      scale = 64'd1;
      while (n != 64'd0) begin
         mirrored = mirrored * b + n % b;
         scale = scale * b;
         n = n / b;
      end
      quot = (mirrored << HPG_FRAC_BITS) / scale;
      return quot[HPG_FRAC_BITS-1:0];
   endfunction

   function automatic point_coords_type predict_point(input logic [HPG_INDEX_BITS-1:0] index);
      point_coords_type p;
      p.x = mirror_fraction(radix_x, index);
      p.y = mirror_fraction(radix_y, index);
      p.z = mirror_fraction(radix_z, index);
      return p;
   endfunction

   function automatic stim_row_type point_row(input logic [HPG_INDEX_BITS-1:0] index);
      stim_row_type r;
      r = '0;
      r.kind = ROW_POINT;
      r.index = index;
      return r;
   endfunction

   function automatic stim_row_type known_row(input logic [HPG_INDEX_BITS-1:0] index,
                                              input logic [HPG_FRAC_BITS-1:0] x,
                                              input logic [HPG_FRAC_BITS-1:0] y,
                                              input logic [HPG_FRAC_BITS-1:0] z);
      stim_row_type r;
      r = point_row(index);
      r.typed = 1'b1;
      r.want = '{x: x, y: y, z: z};
      return r;
   endfunction

   function automatic stim_row_type bases_row(input logic [HPG_BASE_BITS-1:0] bx,
                                              input logic [HPG_BASE_BITS-1:0] by,
                                              input logic [HPG_BASE_BITS-1:0] bz);
      stim_row_type r;
      r = '0;
      r.kind = ROW_BASES;
      r.bx = bx;
      r.by = by;
      r.bz = bz;
      return r;
   endfunction

   function automatic logic [HPG_BASE_BITS-1:0] pick_radix();
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd2;
         3: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // keep most indexes short so base-2 digit passes stay cheap
   function automatic logic [HPG_INDEX_BITS-1:0] pick_index();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 55) return HPG_INDEX_BITS'($urandom_range(0, 255));
      else if (sel < 85) return HPG_INDEX_BITS'($urandom_range(0, 4095));
      else return HPG_INDEX_BITS'($urandom_range(0, (1 << HPG_INDEX_BITS) - 1));
   endfunction

   task automatic flag_mismatch(input string what, input logic [HPG_FRAC_BITS-1:0] got,
                                input logic [HPG_FRAC_BITS-1:0] want);
      $display("[%0d] mismatch %s: got %h expected %h", cycle_count, what, got, want);
      fault_count++;
   endtask

   task automatic send_point(input logic [HPG_INDEX_BITS-1:0] index, input logic typed,
                             input point_coords_type want);
      if ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < gap_pct);
      end
      req_valid <= 1'b1;
      req_point_index <= index;
      do @(posedge clock); while (req_stall);
      coords_due.push_back(typed ? want : predict_point(index));
   endtask

   task automatic put_register(input logic [HPG_CSR_IDX_BITS-1:0] sel,
                               input logic [HPG_BASE_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_bases(input logic [HPG_BASE_BITS-1:0] bx,
                                input logic [HPG_BASE_BITS-1:0] by,
                                input logic [HPG_BASE_BITS-1:0] bz);
      put_register(CSR_SPARE, 8'($urandom_range(0, 255)));
      put_register(CSR_BASE_X, bx);
      put_register(CSR_BASE_Y, by);
      put_register(CSR_BASE_Z, bz);
      csr_valid <= 1'b0;
      radix_x = bx;
      radix_y = by;
      radix_z = bz;
   endtask

   task automatic wait_drained();
      while (coords_due.size() != 0) @(posedge clock);
   endtask

   // check each rsp transfer, then pick the stall for the next cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (coords_due.size() == 0) begin
               flag_mismatch("result with nothing due", rsp_frac_x, '0);
            end else begin
               head_coords = coords_due.pop_front();
               if (rsp_frac_x !== head_coords.x) flag_mismatch("frac_x", rsp_frac_x, head_coords.x);
               if (rsp_frac_y !== head_coords.y) flag_mismatch("frac_y", rsp_frac_y, head_coords.y);
               if (rsp_frac_z !== head_coords.z) flag_mismatch("frac_z", rsp_frac_z, head_coords.z);
            end
         end
         rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
      end
   end

   // hold off the receiver for a long stretch once triggered
   always @(posedge clock) begin
      if (reset) hold_left <= 0;
      else if (hold_trigger) hold_left <= HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due", cycle_count,
                  coords_due.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      steps.push_back(known_row(20'd0, 24'h000000, 24'h000000, 24'h000000));
      steps.push_back(known_row(20'd1, 24'h800000, 24'h555555, 24'h333333));
      steps.push_back(known_row(20'd2, 24'h400000, 24'hAAAAAA, 24'h666666));
      steps.push_back(point_row(20'hFFFFF));
      steps.push_back(point_row(20'h80000));
      steps.push_back(point_row(20'h55555));
      steps.push_back(point_row(20'hAAAAA));
      steps.push_back(bases_row(8'd0, 8'd1, 8'd255));
      steps.push_back(known_row(20'd1, 24'h800000, 24'h800000, 24'h010101));
      steps.push_back(known_row(20'd0, 24'h000000, 24'h000000, 24'h000000));
      steps.push_back(point_row(20'hFFFFF));
      steps.push_back(point_row(20'd254));
      steps.push_back(point_row(20'd255));
      steps.push_back(point_row(20'd3));
      steps.push_back(bases_row(8'd255, 8'd254, 8'd2));
      steps.push_back(point_row(20'hFFFFF));
      steps.push_back(point_row(20'h12345));
      steps.push_back(point_row(20'h00001));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (steps[i]) begin
         if (steps[i].kind == ROW_BASES) begin
            req_valid <= 1'b0;
            wait_drained();
            program_bases(steps[i].bx, steps[i].by, steps[i].bz);
         end else begin
            send_point(steps[i].index, steps[i].typed, steps[i].want);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         req_valid <= 1'b0;
         wait_drained();
         program_bases(pick_radix(), pick_radix(), pick_radix());
         case (p / 3)
            1: begin gap_pct = 77; stall_pct <= 0;  end
            2: begin gap_pct = 0;  stall_pct <= 77; end
            3: begin gap_pct = 18; stall_pct <= 18; end
            default: begin gap_pct = 0; stall_pct <= 0; end
         endcase
         if (p == 0) hold_trigger <= 1'b1;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_point(pick_index(), 1'b0, '0);
            hold_trigger <= 1'b0;
         end
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== halton_point_generator.f =====
rtl/hpg_pkg.sv
rtl/hpg_lane.sv
rtl/halton_point_generator.sv
verif/halton_point_generator_tb.sv
